@@ design/sahash_pkg.sv @@
// Package for the shift-add-xor string hash: widths, queue sizing, divider states
// and the queue status type. No dependencies.
package sahash_pkg;

    localparam int HASH_W   = 32;
    localparam int RANGE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int SHIFT_UP = 5;
    localparam int SHIFT_DN = 2;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int DIV_CNT_W = (HASH_W > 1) ? $clog2(HASH_W) : 1;
    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1024);

    typedef logic [HASH_W-1:0] hash_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic  push;
        hash_t data;
    } q_push_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

    function automatic hash_t hash_step(input hash_t h, input logic [BYTE_W-1:0] b);
        hash_t wb;
        hash_t sum;
        wb  = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        sum = (h << SHIFT_UP) + (h >> SHIFT_DN) + wb;
        return h ^ sum;
    endfunction

endpackage

@@ design/sahash_front.sv @@
// Front end: takes key bytes, keeps the running hash, pushes finished hashes
// into the queue. Depends on sahash_pkg.
module sahash_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sahash_pkg::BYTE_W-1:0]    s_key_byte,
    input  logic                             s_end_of_key,
    input  sahash_pkg::q_stat_t              q_stat,
    output sahash_pkg::q_push_t              q_push
);

    sahash_pkg::hash_t hash_reg;
    sahash_pkg::hash_t hash_next;
    logic              accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hash_next = hash_reg;
        if (accept) begin
            if (s_end_of_key) begin
                hash_next = '0;
            end else begin
                hash_next = sahash_pkg::hash_step(hash_reg, s_key_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else begin
            hash_reg <= hash_next;
        end
    end

    assign q_push.push = accept && s_end_of_key;
    assign q_push.data = hash_reg;

endmodule

@@ design/sahash_queue.sv @@
// Short queue of finished hashes between front end and divider.
// Depends on sahash_pkg.
module sahash_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sahash_pkg::q_push_t  q_push,
    input  logic                 pop,
    output sahash_pkg::hash_t    head,
    output sahash_pkg::q_stat_t  q_stat
);

    sahash_pkg::hash_t                 mem_reg [sahash_pkg::Q_DEPTH];
    logic [sahash_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sahash_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sahash_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;

    function automatic logic [sahash_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [sahash_pkg::Q_PTR_W-1:0] p);
        logic [sahash_pkg::Q_PTR_W-1:0] r;
        if (p == sahash_pkg::Q_PTR_W'(sahash_pkg::Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == sahash_pkg::Q_CNT_W'(sahash_pkg::Q_DEPTH));
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = q_push.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push.push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !q_push.push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            mem_reg[wr_ptr_reg] <= q_push.data;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.push |-> !q_stat.full)
        else $error("push into full queue");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= sahash_pkg::Q_CNT_W'(sahash_pkg::Q_DEPTH))
        else $error("queue count overrun");

endmodule

@@ design/sahash_div.sv @@
// Back end: restoring divider, one quotient bit per cycle, reduces each hash
// modulo a nonzero range and drives the result register. Depends on sahash_pkg.
module sahash_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [sahash_pkg::RANGE_W-1:0]    table_range,
    input  sahash_pkg::q_stat_t               q_stat,
    input  sahash_pkg::hash_t                 head,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sahash_pkg::RANGE_W-1:0]    m_bucket_index
);

    sahash_pkg::div_state_t                 state_reg, state_next;
    sahash_pkg::hash_t                      dvd_reg, dvd_next;
    logic [sahash_pkg::RANGE_W-1:0]         rem_reg, rem_next;
    logic [sahash_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [sahash_pkg::RANGE_W-1:0]         out_data_reg, out_data_next;

    logic                                   range_zero;
    logic                                   out_free;
    logic                                   load_out;
    logic                                   start;
    logic [sahash_pkg::RANGE_W:0]           rem_shift;
    logic [sahash_pkg::RANGE_W:0]           rem_diff;

    assign range_zero = (table_range == '0);
    assign out_free   = !out_valid_reg || m_ready;
    assign rem_shift  = {rem_reg, dvd_reg[sahash_pkg::HASH_W-1]};
    assign rem_diff   = rem_shift - {1'b0, table_range};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sahash_pkg::DIV_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = range_zero ? sahash_pkg::DIV_HOLD : sahash_pkg::DIV_RUN;
                end
            end
            sahash_pkg::DIV_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = sahash_pkg::DIV_HOLD;
                end
            end
            sahash_pkg::DIV_HOLD: begin
                if (out_free) begin
                    state_next = sahash_pkg::DIV_IDLE;
                end
            end
            default: state_next = sahash_pkg::DIV_IDLE;
        endcase
    end

    always_comb begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            sahash_pkg::DIV_IDLE: start    = !q_stat.empty;
            sahash_pkg::DIV_RUN:  start    = 1'b0;
            sahash_pkg::DIV_HOLD: load_out = out_free;
            default: begin
                start    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign pop = start;

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            dvd_next = head;
            rem_next = range_zero ? sahash_pkg::RANGE_W'(head) : '0;
            cnt_next = sahash_pkg::DIV_CNT_W'(sahash_pkg::HASH_W - 1);
        end else if (state_reg == sahash_pkg::DIV_RUN) begin
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (!rem_diff[sahash_pkg::RANGE_W]) begin
                rem_next = rem_diff[sahash_pkg::RANGE_W-1:0];
            end else begin
                rem_next = rem_shift[sahash_pkg::RANGE_W-1:0];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = rem_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sahash_pkg::DIV_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_bucket_index = out_data_reg;

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sahash_pkg::DIV_HOLD) && !range_zero |-> rem_reg < table_range)
        else $error("remainder not below range");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == sahash_pkg::DIV_IDLE)
        else $error("pop while divider busy");

    a_load_after_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid && (state_reg == sahash_pkg::DIV_IDLE))
        else $error("result load did not take effect");

endmodule

@@ design/shift_add_xor_string_hash.sv @@
// Shift-add-xor string hash, top level. Key bytes hash at one per cycle while the
// queue is not full; each terminator pushes the finished hash into the queue, and the
// divider reduces it modulo the range and loads the result for hand-off. A two-entry
// queue decouples hashing from division.
// Synchronous active-low reset: hash cleared, queue empty, range set to 1024.
module shift_add_xor_string_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sahash_pkg::BYTE_W-1:0]     s_key_byte,
    input  logic                              s_end_of_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sahash_pkg::RANGE_W-1:0]    m_bucket_index,
    input  logic                              cfg_wr_en,
    input  logic [sahash_pkg::RANGE_W-1:0]    cfg_wr_data
);

    logic [sahash_pkg::RANGE_W-1:0] table_range_reg;
    sahash_pkg::q_stat_t            q_stat;
    sahash_pkg::q_push_t            q_push;
    sahash_pkg::hash_t              head;
    logic                           pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_range_reg <= sahash_pkg::RANGE_RESET;
        end else if (cfg_wr_en) begin
            table_range_reg <= cfg_wr_data;
        end
    end

    sahash_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_byte   (s_key_byte),
        .s_end_of_key (s_end_of_key),
        .q_stat       (q_stat),
        .q_push       (q_push)
    );

    sahash_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    sahash_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .table_range    (table_range_reg),
        .q_stat         (q_stat),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the shift-add-xor string hash: random keys over valid/ready,
// a local hash predictor and bucket check across several table ranges. Needs sahash_pkg.
module tb_top;

    localparam int DRAIN_CYCLES = 45;
    localparam int PHASE_ITEMS  = 205;
    localparam int N_PHASES     = 8;

    typedef struct packed {
        logic [sahash_pkg::BYTE_W-1:0] key_byte;
        logic                          end_of_key;
    } key_item_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [sahash_pkg::BYTE_W-1:0]     s_key_byte = '0;
    logic                              s_end_of_key = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [sahash_pkg::RANGE_W-1:0]    m_bucket_index;
    logic                              cfg_wr_en = 1'b0;
    logic [sahash_pkg::RANGE_W-1:0]    cfg_wr_data = '0;

    key_item_t                         pending_bytes[$];
    logic [sahash_pkg::RANGE_W-1:0]    expected_buckets[$];
    logic [sahash_pkg::HASH_W-1:0]     key_hash = '0;
    logic [sahash_pkg::RANGE_W-1:0]    bucket_range = sahash_pkg::RANGE_RESET;
    int                                n_queued = 0;
    int                                n_accepted = 0;
    int                                n_errors = 0;
    int                                send_idle_pct = 0;
    int                                recv_stall_pct = 0;
    logic                              hold_sender = 1'b0;

    shift_add_xor_string_hash dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_end_of_key   (s_end_of_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [sahash_pkg::HASH_W-1:0] mix_byte(
        logic [sahash_pkg::HASH_W-1:0] h, logic [sahash_pkg::BYTE_W-1:0] b);
        logic [sahash_pkg::HASH_W-1:0] wide;
        logic [sahash_pkg::HASH_W-1:0] sum;
        wide = {{(sahash_pkg::HASH_W-sahash_pkg::BYTE_W){b[sahash_pkg::BYTE_W-1]}}, b};
        sum  = (h << 5) + (h >> 2) + wide;
        return h ^ sum;
    endfunction

    function automatic logic [sahash_pkg::RANGE_W-1:0] bucket_of(
        logic [sahash_pkg::HASH_W-1:0] h, logic [sahash_pkg::RANGE_W-1:0] range);
        logic [sahash_pkg::HASH_W-1:0] r;
        // a zero range passes the hash straight through
        r = (range == '0) ? h : h % range;
        return r[sahash_pkg::RANGE_W-1:0];
    endfunction

    // driver: predicts on each accepted transaction
    always @(posedge aclk) begin
        key_item_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            key_hash = '0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_end_of_key) begin
                    expected_buckets.push_back(bucket_of(key_hash, bucket_range));
                    key_hash = '0;
                end else begin
                    key_hash = mix_byte(key_hash, s_key_byte);
                end
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    s_valid      <= 1'b1;
                    s_key_byte   <= nxt.key_byte;
                    s_end_of_key <= nxt.end_of_key;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [sahash_pkg::RANGE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_buckets.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected bucket %0d", m_bucket_index);
                end else begin
                    want = expected_buckets.pop_front();
                    if (m_bucket_index !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("bucket mismatch: expected %0d, got %0d",
                                     want, m_bucket_index);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(logic [sahash_pkg::BYTE_W-1:0] b, logic last);
        key_item_t it;
        it.key_byte   = b;
        it.end_of_key = last;
        pending_bytes.push_back(it);
        n_queued++;
    endtask

    task automatic queue_random_key(output int n_items);
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        for (int i = 0; i < len; i++)
            queue_item(sahash_pkg::BYTE_W'($urandom_range(255)), 1'b0);
        queue_item(sahash_pkg::BYTE_W'($urandom_range(255)), 1'b1);
        n_items = len + 1;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_buckets.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_range(logic [sahash_pkg::RANGE_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        bucket_range = v;
    endtask

    initial begin
        logic [sahash_pkg::RANGE_W-1:0] range_val;
        int n_items;
        int phase_items;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed keys under the reset range
        queue_item(8'hA5, 1'b1);
        queue_item(8'h00, 1'b0); queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b0); queue_item(8'hFF, 1'b1);
        queue_item(8'h80, 1'b0); queue_item(8'h7F, 1'b0); queue_item(8'h55, 1'b1);
        queue_item(8'h01, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_item(8'hFF, 1'b0);
        queue_item(8'h00, 1'b1);
        queue_item(8'h41, 1'b0); queue_item(8'h42, 1'b0); queue_item(8'h43, 1'b0);
        queue_item(8'hFF, 1'b1);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: range_val = 32'd1024;
                1: range_val = 32'd1;
                2: range_val = 32'hFFFF_FFFF;
                3: range_val = 32'd0;
                4: range_val = $urandom();
                5: range_val = $urandom_range(300, 2);
                6: range_val = 32'h8000_0000;
                default: range_val = $urandom_range(70000, 2);
            endcase
            write_range(range_val);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                queue_random_key(n_items);
                phase_items += n_items;
            end
            if (p == 2) begin
                while (n_accepted < n_queued - PHASE_ITEMS / 2)
                    @(posedge aclk);
                hold_sender = 1'b1;
                while (expected_buckets.size() != 0)
                    @(posedge aclk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        n_errors += expected_buckets.size();
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
